>>> rtl/core/scbd_pkg.sv
// Package with the shared types and constants of the SCSI block command decoder.
`default_nettype none
package scbd_pkg;

    // SCSI operation codes.
    localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
    localparam logic [7:0] OP_REQUEST_SENSE   = 8'h03;
    localparam logic [7:0] OP_INQUIRY         = 8'h12;
    localparam logic [7:0] OP_MODE_SENSE6     = 8'h1A;
    localparam logic [7:0] OP_START_STOP      = 8'h1B;
    localparam logic [7:0] OP_PREVENT_REMOVAL = 8'h1E;
    localparam logic [7:0] OP_READ_CAPACITY10 = 8'h25;
    localparam logic [7:0] OP_READ10          = 8'h28;
    localparam logic [7:0] OP_WRITE10         = 8'h2A;
    localparam logic [7:0] OP_SYNC_CACHE      = 8'h35;
    localparam logic [7:0] OP_MODE_SENSE10    = 8'h5A;

    // Sense values.
    localparam logic [7:0] SENSE_KEY_NONE      = 8'h00;
    localparam logic [7:0] SENSE_KEY_ILLEGAL   = 8'h05;
    localparam logic [7:0] SENSE_CODE_NONE     = 8'h00;
    localparam logic [7:0] SENSE_CODE_BAD_OP   = 8'h20;
    localparam logic [7:0] SENSE_CODE_LBA_OOR  = 8'h21;

    // Reply byte constants.
    localparam logic [7:0] SENSE_RESP_CODE     = 8'h70;
    localparam logic [7:0] SENSE_ADD_LENGTH    = 8'd10;
    localparam logic [7:0] INQ_REMOVABLE       = 8'h80;
    localparam logic [7:0] INQ_VERSION         = 8'h04;
    localparam logic [7:0] INQ_RESP_FORMAT     = 8'h02;
    localparam logic [7:0] INQ_ADD_LENGTH      = 8'd31;
    localparam logic [7:0] MS6_DATA_LENGTH     = 8'd3;
    localparam logic [7:0] MS10_DATA_LENGTH    = 8'd6;

    // Reply lengths in bytes.
    localparam logic [5:0] LEN_INQUIRY         = 6'd36;
    localparam logic [5:0] LEN_SENSE           = 6'd18;
    localparam logic [5:0] LEN_CAPACITY        = 6'd8;
    localparam logic [5:0] LEN_MODE_SENSE6     = 6'd4;
    localparam logic [5:0] LEN_MODE_SENSE10    = 6'd8;
    localparam int         REPLY_MAX           = 36;

    // Output item codes.
    localparam logic       KIND_OUTCOME        = 1'b0;
    localparam logic       KIND_DATA           = 1'b1;
    localparam logic [1:0] ACT_NONE            = 2'd0;
    localparam logic [1:0] ACT_REPLY           = 2'd1;
    localparam logic [1:0] ACT_READ            = 2'd2;
    localparam logic [1:0] ACT_WRITE           = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_MEDIUM_BLOCKS   = 3'd0;
    localparam logic [2:0] REG_PRODUCT_UPPER   = 3'd1;
    localparam logic [2:0] REG_PRODUCT_LOWER   = 3'd2;
    localparam logic [2:0] REG_VENDOR_IDENT    = 3'd3;
    localparam logic [2:0] REG_REVISION_IDENT  = 3'd4;

    localparam logic [63:0] SPACES64           = 64'h2020202020202020;
    localparam logic [31:0] SPACES32           = 32'h20202020;

    // Depth of the job queue between front and back.
    localparam int QDEPTH = 4;

    typedef enum logic [2:0] {
        RT_NONE,
        RT_INQUIRY,
        RT_SENSE,
        RT_CAPACITY,
        RT_MS6,
        RT_MS10,
        RT_RW,
        RT_BAD
    } t_rtype;

    typedef struct packed {
        logic [7:0]  scsi_opcode;
        logic [31:0] cdb_lba;
        logic [15:0] cdb_blocks;
        logic [31:0] host_length;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [1:0]  action;
        logic [31:0] transfer_lba;
        logic [15:0] transfer_blocks;
        logic [31:0] transfer_bytes;
        logic [31:0] residue;
        logic        failed;
        logic [5:0]  reply_length;
        logic [7:0]  data_byte;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [31:0] medium_blocks;
        logic [63:0] product_upper;
        logic [63:0] product_lower;
        logic [63:0] vendor_ident;
        logic [31:0] revision_ident;
    } t_cfg;

    // One classified command waiting for the back end.
    typedef struct packed {
        t_rtype      rtype;
        logic [1:0]  action;
        logic [31:0] lba;
        logic [15:0] blocks;
        logic [31:0] bytes;
        logic [31:0] residue;
        logic        failed;
        logic [5:0]  rlen;
        logic [7:0]  sns_key;
        logic [7:0]  sense_code;
    } t_job;

endpackage
`default_nettype wire

>>> rtl/core/scbd_regs.sv
// Configuration register file of the SCSI block command decoder.
`default_nettype none
module scbd_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [63:0]   i_cfg_data,
    output scbd_pkg::t_cfg     o_cfg
);
    import scbd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.medium_blocks  <= '0;
            r_cfg.product_upper  <= SPACES64;
            r_cfg.product_lower  <= SPACES64;
            r_cfg.vendor_ident   <= SPACES64;
            r_cfg.revision_ident <= SPACES32;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MEDIUM_BLOCKS:  r_cfg.medium_blocks  <= i_cfg_data[31:0];
                REG_PRODUCT_UPPER:  r_cfg.product_upper  <= i_cfg_data;
                REG_PRODUCT_LOWER:  r_cfg.product_lower  <= i_cfg_data;
                REG_VENDOR_IDENT:   r_cfg.vendor_ident   <= i_cfg_data;
                REG_REVISION_IDENT: r_cfg.revision_ident <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

>>> rtl/core/scbd_front.sv
// Front end: accepts commands, checks ranges, keeps the sense and builds queue jobs.
`default_nettype none
module scbd_front #(
    parameter int BLOCK_BYTES = 512
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire scbd_pkg::t_in i_in_data,
    input  wire logic [31:0]   i_medium_blocks,
    output logic               o_push,
    output scbd_pkg::t_job     o_job,
    input  wire logic          i_full
);
    import scbd_pkg::*;

    localparam logic [31:0] BB = 32'(BLOCK_BYTES);

    logic        w_acc;
    logic        w_is_rw;
    logic        w_range_ok;
    t_rtype      w_rtype;
    logic [31:0] w_room;
    logic [31:0] w_prod;

    logic [7:0]  r_sns_key;
    logic [7:0]  r_sense_code;

    logic        r_s1_valid;
    t_rtype      r_s1_rtype;
    logic        r_s1_fail;
    logic        r_s1_write;
    logic [31:0] r_s1_lba;
    logic [15:0] r_s1_blocks;
    logic [31:0] r_s1_host;
    logic [31:0] r_s1_prod;
    logic [7:0]  r_s1_key;
    logic [7:0]  r_s1_code;

    logic [5:0]  w_base_len;
    logic [5:0]  w_len;
    logic [31:0] w_bytes;

    assign o_in_stall = r_s1_valid && i_full;
    assign w_acc      = i_in_valid && !o_in_stall;

    always_comb begin
        case (i_in_data.scsi_opcode)
            OP_TEST_UNIT_READY, OP_START_STOP,
            OP_PREVENT_REMOVAL, OP_SYNC_CACHE: w_rtype = RT_NONE;
            OP_INQUIRY:         w_rtype = RT_INQUIRY;
            OP_REQUEST_SENSE:   w_rtype = RT_SENSE;
            OP_READ_CAPACITY10: w_rtype = RT_CAPACITY;
            OP_MODE_SENSE6:     w_rtype = RT_MS6;
            OP_MODE_SENSE10:    w_rtype = RT_MS10;
            OP_READ10, OP_WRITE10: w_rtype = RT_RW;
            default:            w_rtype = RT_BAD;
        endcase
    end

    assign w_is_rw    = (w_rtype == RT_RW);
    assign w_room     = i_medium_blocks - i_in_data.cdb_lba;
    // A zero block count passes whatever the address.
    assign w_range_ok = (i_in_data.cdb_blocks == 16'd0) ||
                        ((i_in_data.cdb_lba < i_medium_blocks) &&
                         ({16'd0, i_in_data.cdb_blocks} <= w_room));
    assign w_prod     = {16'd0, i_in_data.cdb_blocks} * BB;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sns_key    <= SENSE_KEY_NONE;
            r_sense_code <= SENSE_CODE_NONE;
            r_s1_valid   <= 1'b0;
        end else begin
            if (w_acc) begin
                if (w_is_rw && !w_range_ok) begin
                    r_sns_key    <= SENSE_KEY_ILLEGAL;
                    r_sense_code <= SENSE_CODE_LBA_OOR;
                end else if (w_rtype == RT_BAD) begin
                    r_sns_key    <= SENSE_KEY_ILLEGAL;
                    r_sense_code <= SENSE_CODE_BAD_OP;
                end else if (w_rtype == RT_SENSE) begin
                    r_sns_key    <= SENSE_KEY_NONE;
                    r_sense_code <= SENSE_CODE_NONE;
                end
                r_s1_valid <= 1'b1;
            end else if (o_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_rtype  <= w_rtype;
            r_s1_fail   <= (w_is_rw && !w_range_ok) || (w_rtype == RT_BAD);
            r_s1_write  <= (i_in_data.scsi_opcode == OP_WRITE10);
            r_s1_lba    <= i_in_data.cdb_lba;
            r_s1_blocks <= i_in_data.cdb_blocks;
            r_s1_host   <= i_in_data.host_length;
            r_s1_prod   <= w_prod;
            // The sense as it stood before this command is what a sense reply reports.
            r_s1_key    <= r_sns_key;
            r_s1_code   <= r_sense_code;
        end
    end

    always_comb begin
        case (r_s1_rtype)
            RT_INQUIRY:  w_base_len = LEN_INQUIRY;
            RT_SENSE:    w_base_len = LEN_SENSE;
            RT_CAPACITY: w_base_len = LEN_CAPACITY;
            RT_MS6:      w_base_len = LEN_MODE_SENSE6;
            RT_MS10:     w_base_len = LEN_MODE_SENSE10;
            default:     w_base_len = 6'd0;
        endcase
    end

    assign w_len   = (r_s1_host < {26'd0, w_base_len}) ? r_s1_host[5:0] : w_base_len;
    assign w_bytes = (r_s1_prod > r_s1_host) ? r_s1_host : r_s1_prod;

    assign o_push = r_s1_valid && !i_full;

    always_comb begin
        o_job            = '0;
        o_job.rtype      = r_s1_rtype;
        o_job.sns_key    = r_s1_key;
        o_job.sense_code = r_s1_code;
        if (r_s1_fail) begin
            o_job.action  = ACT_NONE;
            o_job.residue = r_s1_host;
            o_job.failed  = 1'b1;
        end else if (r_s1_rtype == RT_RW) begin
            o_job.action  = r_s1_write ? ACT_WRITE : ACT_READ;
            o_job.lba     = r_s1_lba;
            o_job.blocks  = r_s1_blocks;
            o_job.bytes   = w_bytes;
            o_job.residue = r_s1_host - w_bytes;
        end else begin
            o_job.action  = (w_len != 6'd0) ? ACT_REPLY : ACT_NONE;
            o_job.rlen    = w_len;
            o_job.residue = r_s1_host - {26'd0, w_len};
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/scbd_queue.sv
// Short job queue that decouples the front end from the back end.
`default_nettype none
module scbd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire scbd_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output scbd_pkg::t_job      o_job
);
    import scbd_pkg::*;

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    t_job          r_mem [QDEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_do_push;
    logic          w_do_pop;

    assign o_full    = (r_count == CW'(QDEPTH));
    assign o_valid   = (r_count != '0);
    assign o_job     = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/scbd_back.sv
// Back end: sends the outcome of each job and then its reply bytes.
`default_nettype none
module scbd_back #(
    parameter int BLOCK_BYTES = 512
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire scbd_pkg::t_job i_q_job,
    output logic                o_pop,
    input  wire scbd_pkg::t_cfg i_cfg,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output scbd_pkg::t_out      o_out_data
);
    import scbd_pkg::*;

    localparam logic [31:0] BB = 32'(BLOCK_BYTES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OUTCOME,
        ST_DATA
    } t_state;

    t_state      r_state;
    t_job        r_job;
    logic [5:0]  r_idx;
    logic        r_out_valid;
    t_out        r_out;

    logic [7:0]  w_reply [REPLY_MAX];
    logic [31:0] w_last_lba;
    logic        w_free;
    logic        w_emit;
    logic        w_done;
    t_out        w_item;

    assign w_last_lba = i_cfg.medium_blocks - 32'd1;

    always_comb begin
        for (int k = 0; k < REPLY_MAX; k++) begin
            w_reply[k] = 8'h00;
        end
        case (r_job.rtype)
            RT_INQUIRY: begin
                w_reply[1] = INQ_REMOVABLE;
                w_reply[2] = INQ_VERSION;
                w_reply[3] = INQ_RESP_FORMAT;
                w_reply[4] = INQ_ADD_LENGTH;
                for (int k = 0; k < 8; k++) begin
                    w_reply[8 + k]  = i_cfg.vendor_ident[63 - 8*k -: 8];
                    w_reply[16 + k] = i_cfg.product_upper[63 - 8*k -: 8];
                    w_reply[24 + k] = i_cfg.product_lower[63 - 8*k -: 8];
                end
                for (int k = 0; k < 4; k++) begin
                    w_reply[32 + k] = i_cfg.revision_ident[31 - 8*k -: 8];
                end
            end
            RT_SENSE: begin
                w_reply[0]  = SENSE_RESP_CODE;
                w_reply[2]  = r_job.sns_key;
                w_reply[7]  = SENSE_ADD_LENGTH;
                w_reply[12] = r_job.sense_code;
            end
            RT_CAPACITY: begin
                for (int k = 0; k < 4; k++) begin
                    w_reply[k]     = w_last_lba[31 - 8*k -: 8];
                    w_reply[4 + k] = BB[31 - 8*k -: 8];
                end
            end
            RT_MS6:  w_reply[0] = MS6_DATA_LENGTH;
            RT_MS10: w_reply[1] = MS10_DATA_LENGTH;
            default: ;
        endcase
    end

    always_comb begin
        w_item = '0;
        if (r_state == ST_DATA) begin
            w_item.kind      = KIND_DATA;
            w_item.data_byte = w_reply[r_idx];
            w_item.last      = ((r_idx + 6'd1) == r_job.rlen);
        end else begin
            w_item.kind            = KIND_OUTCOME;
            w_item.action          = r_job.action;
            w_item.transfer_lba    = r_job.lba;
            w_item.transfer_blocks = r_job.blocks;
            w_item.transfer_bytes  = r_job.bytes;
            w_item.residue         = r_job.residue;
            w_item.failed          = r_job.failed;
            w_item.reply_length    = r_job.rlen;
            w_item.last            = (r_job.rlen == 6'd0);
        end
    end

    assign w_free = !r_out_valid || !i_out_stall;
    assign w_emit = (r_state != ST_IDLE) && w_free;
    assign w_done = w_emit && w_item.last;
    // The next job is taken in the same cycle that the last item of this one goes out.
    assign o_pop  = i_q_valid && ((r_state == ST_IDLE) || w_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (o_pop) begin
                r_state <= ST_OUTCOME;
                r_idx   <= '0;
            end else if (w_done) begin
                r_state <= ST_IDLE;
            end else if (w_emit) begin
                if (r_state == ST_OUTCOME) begin
                    r_state <= ST_DATA;
                end else begin
                    r_idx <= r_idx + 6'd1;
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_out       <= w_item;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

>>> rtl/core/scsi_block_command_decoder_top.sv
// Top level of the SCSI block command decoder.
// Path: an accepted command passes the front check stage, the job queue and the
// back-end job register before its outcome item is registered at the output.
// Throughput: the front accepts a command every cycle while the four-entry job queue
// has room; the back end sends one item a cycle while the output is not stalled.
// Reset is synchronous and active low; it clears the sense, the queue and the
// handshakes and loads the configuration registers with their reset values.
`default_nettype none
module scsi_block_command_decoder_top #(
    parameter int BLOCK_BYTES = 512
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [63:0]   i_cfg_data,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire scbd_pkg::t_in i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output scbd_pkg::t_out     o_out_data
);
    import scbd_pkg::*;

    t_cfg w_cfg;
    logic w_push;
    t_job w_push_job;
    logic w_full;
    logic w_pop;
    logic w_q_valid;
    t_job w_q_job;

    scbd_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    scbd_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_data       (i_in_data),
        .i_medium_blocks (w_cfg.medium_blocks),
        .o_push          (w_push),
        .o_job           (w_push_job),
        .i_full          (w_full)
    );

    scbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    scbd_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_job     (w_q_job),
        .o_pop       (w_pop),
        .i_cfg       (w_cfg),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

>>> rtl/core/scbd_checker.sv
// Port-level checker of the SCSI block command decoder and its bind statement.
`default_nettype none
module scbd_checker (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           o_in_stall,
    input  wire logic           o_out_valid,
    input  wire logic           i_out_stall,
    input  wire scbd_pkg::t_out o_out_data
);
    import scbd_pkg::*;

    logic       w_out_acc;
    logic [5:0] r_pending;

    assign w_out_acc = o_out_valid && !i_out_stall;

    // Reply bytes still owed by the last outcome transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_out_acc) begin
            if (o_out_data.kind == KIND_OUTCOME) begin
                r_pending <= o_out_data.reply_length;
            end else begin
                r_pending <= r_pending - 6'd1;
            end
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("handshakes not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output transaction changed");

    a_kind_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> (o_out_data.kind == KIND_DATA) == (r_pending != 6'd0))
        else $error("reply byte count does not match the outcome");

    a_last_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && o_out_data.kind == KIND_DATA |-> o_out_data.last == (r_pending == 6'd1))
        else $error("last flag misplaced in reply bytes");

endmodule

bind scsi_block_command_decoder_top scbd_checker u_scbd_checker (.*);
`default_nettype wire
